// ----- rtl/snooping_coherent_cache_controller_defines.svh -----
// Assertion helpers for the RTL
`ifndef SNOOPING_COHERENT_CACHE_CONTROLLER_DEFINES_SVH
`define SNOOPING_COHERENT_CACHE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SCCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sccc_pkg.sv -----
package sccc_pkg;

	localparam int NUM_SETS_DEF   = 64;
	localparam int WAYS_DEF       = 4;
	localparam int LINE_BYTES_DEF = 64;
	localparam int ADDR_BITS      = 32;
	localparam int STAMP_W        = 32;

	// item kinds
	localparam logic [2:0] KIND_PR_RD      = 3'd0;
	localparam logic [2:0] KIND_PR_WR      = 3'd1;
	localparam logic [2:0] KIND_BUS_RD     = 3'd2;
	localparam logic [2:0] KIND_BUS_RDX    = 3'd3;
	localparam logic [2:0] KIND_BUS_UPGR   = 3'd4;
	localparam logic [2:0] KIND_BUS_UPDATE = 3'd5;

	// line states
	localparam logic [2:0] ST_I  = 3'd0;
	localparam logic [2:0] ST_S  = 3'd1;
	localparam logic [2:0] ST_E  = 3'd2;
	localparam logic [2:0] ST_M  = 3'd3;
	localparam logic [2:0] ST_SM = 3'd4;

	// protocol register codes
	localparam logic [1:0] PROTO_MSI    = 2'd0;
	localparam logic [1:0] PROTO_MESI   = 2'd1;
	localparam logic [1:0] PROTO_DRAGON = 2'd2;

	typedef enum logic [1:0] {
		MODE_MSI    = 2'd0,
		MODE_MESI   = 2'd1,
		MODE_DRAGON = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [ADDR_BITS-1:0] address;
		logic                 others_have_copy;
	} sccc_item_t;

	typedef struct packed {
		logic       hit;
		logic       bus_read;
		logic       bus_read_excl;
		logic       bus_upgrade;
		logic       bus_update;
		logic       flush;
		logic       victim_writeback;
		logic [2:0] line_state;
	} sccc_result_t;

endpackage

// ----- rtl/snooping_coherent_cache_controller.sv -----
// Coherence controller for one private set-associative cache (MSI, MESI or Dragon,
// chosen by the protocol register, reset MESI). After reset the block sweeps the
// line-state and age memories, one line a cycle, over all NUM_SETS*WAYS lines before
// it takes its first item; configuration writes are taken during the sweep. An
// item is handled in steps, its transfer cycle included: it is latched, then
// each way of the set is read and then compared, way after way, through the single
// tag/state/age read port and comparator, and last the chosen line is written
// back and the result register loaded. A reserved kind skips the way scan and
// goes straight to the write-back step. The next item may be transferred while
// a finished result still waits in the output register; its write-back cycle
// then waits until that earlier result has been taken.
`include "snooping_coherent_cache_controller_defines.svh"

module snooping_coherent_cache_controller #(
	parameter int NUM_SETS   = sccc_pkg::NUM_SETS_DEF,
	parameter int WAYS       = sccc_pkg::WAYS_DEF,
	parameter int LINE_BYTES = sccc_pkg::LINE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  sccc_pkg::sccc_item_t  item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output sccc_pkg::sccc_result_t result
);
	import sccc_pkg::*;

	localparam int OFF_W    = $clog2(LINE_BYTES + 1) - 1;
	localparam int SET_W    = $clog2(NUM_SETS + 1) - 1;
	localparam int SET_IW   = (SET_W > 0) ? SET_W : 1;
	localparam int SET_MASK = (1 << SET_W) - 1;
	localparam int TAG_W    = ADDR_BITS - OFF_W - SET_W;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINES    = NUM_SETS * WAYS;
	localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1;

	typedef enum logic [4:0] {
		S_CLR  = 5'b00001,
		S_IDLE = 5'b00010,
		S_READ = 5'b00100,
		S_CMP  = 5'b01000,
		S_FIN  = 5'b10000
	} fsm_t;

	fsm_t                 state_q;
	logic [1:0]           protocol_q;
	logic [STAMP_W-1:0]   count_q;
	logic [LINE_W-1:0]    clr_q;
	logic [WAY_W-1:0]     way_q;

	logic [2:0]           kind_q;
	logic                 others_q;
	logic [SET_IW-1:0]    set_q;
	logic [TAG_W-1:0]     tag_q;

	logic                 found_q;
	logic [WAY_W-1:0]     hit_way_q;
	logic [2:0]           hit_st_q;
	logic                 inv_found_q;
	logic [WAY_W-1:0]     inv_way_q;
	logic [STAMP_W-1:0]   min_age_q;
	logic [WAY_W-1:0]     min_way_q;
	logic [2:0]           min_st_q;

	logic [TAG_W-1:0]     tag_mem [LINES];
	logic [2:0]           st_mem  [LINES];
	logic [STAMP_W-1:0]   age_mem [LINES];
	logic [TAG_W-1:0]     tag_rd_q;
	logic [2:0]           st_rd_q;
	logic [STAMP_W-1:0]   age_rd_q;

	sccc_result_t         result_q;
	logic                 result_valid_q;

	mode_t                mode;
	logic                 item_xfer;
	logic                 fin_go;
	logic                 last_way;
	logic                 is_proc;
	logic                 is_wr;
	logic                 is_snoop;
	logic [WAY_W-1:0]     vic_way;
	logic [2:0]           vic_st;
	logic [LINE_W-1:0]    rd_idx;
	logic [LINE_W-1:0]    wr_idx;
	logic [WAY_W-1:0]     wr_way;
	logic                 wr_tag;
	logic                 wr_st;
	logic                 wr_age;
	logic [2:0]           new_st;
	logic [2:0]           st_wd;
	logic [STAMP_W-1:0]   age_wd;
	sccc_result_t         res_d;
	logic [2:0]           req_vec;

	assign item_ready   = (state_q == S_IDLE);
	assign item_xfer    = item_valid && item_ready;
	assign fin_go       = (state_q == S_FIN) && (!result_valid_q || result_ready);
	assign last_way     = (way_q == WAY_W'(WAYS - 1));
	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign req_vec      = {result_q.bus_read_excl, result_q.bus_upgrade, result_q.bus_update};

	always_comb begin
		case (protocol_q)
			PROTO_MSI:    mode = MODE_MSI;
			PROTO_DRAGON: mode = MODE_DRAGON;
			default:      mode = MODE_MESI;
		endcase
	end

	assign is_proc  = (kind_q == KIND_PR_RD) || (kind_q == KIND_PR_WR);
	assign is_wr    = (kind_q == KIND_PR_WR);
	assign is_snoop = (kind_q == KIND_BUS_RD) || (kind_q == KIND_BUS_RDX) ||
		(kind_q == KIND_BUS_UPGR) || (kind_q == KIND_BUS_UPDATE);
	assign vic_way  = inv_found_q ? inv_way_q : min_way_q;
	assign vic_st   = inv_found_q ? ST_I : min_st_q;

	assign rd_idx = LINE_W'(32'(set_q) * 32'(WAYS) + 32'(way_q));
	assign wr_idx = (state_q == S_CLR) ? clr_q :
		LINE_W'(32'(set_q) * 32'(WAYS) + 32'(wr_way));

	// outcome of the item, from the scan results
	always_comb begin
		res_d  = '0;
		wr_tag = 1'b0;
		wr_st  = 1'b0;
		wr_age = 1'b0;
		wr_way = hit_way_q;
		new_st = ST_I;
		if (is_proc) begin
			if (found_q) begin
				res_d.hit = 1'b1;
				wr_st     = 1'b1;
				wr_age    = 1'b1;
				new_st    = hit_st_q;
				if (is_wr) begin
					case (mode)
						MODE_MSI: begin
							if (hit_st_q == ST_S) begin
								new_st              = ST_M;
								res_d.bus_read_excl = 1'b1;
							end
						end
						MODE_MESI: begin
							if (hit_st_q == ST_S) begin
								new_st            = ST_M;
								res_d.bus_upgrade = 1'b1;
							end else if (hit_st_q == ST_E) begin
								new_st = ST_M;
							end
						end
						default: begin
							if (hit_st_q == ST_E) begin
								new_st = ST_M;
							end else if (hit_st_q == ST_S || hit_st_q == ST_SM) begin
								new_st           = others_q ? ST_SM : ST_M;
								res_d.bus_update = 1'b1;
							end
						end
					endcase
				end
			end else begin
				wr_way                 = vic_way;
				wr_tag                 = 1'b1;
				wr_st                  = 1'b1;
				wr_age                 = 1'b1;
				res_d.victim_writeback = (vic_st == ST_M) || (vic_st == ST_SM);
				if (mode == MODE_DRAGON) begin
					res_d.bus_read = 1'b1;
					if (is_wr) begin
						new_st           = others_q ? ST_SM : ST_M;
						res_d.bus_update = others_q;
					end else begin
						new_st = others_q ? ST_S : ST_E;
					end
				end else if (is_wr) begin
					new_st              = ST_M;
					res_d.bus_read_excl = 1'b1;
				end else begin
					new_st         = (mode == MODE_MESI && !others_q) ? ST_E : ST_S;
					res_d.bus_read = 1'b1;
				end
			end
		end else if (is_snoop && found_q) begin
			res_d.hit = 1'b1;
			wr_st     = 1'b1;
			new_st    = hit_st_q;
			if (mode == MODE_DRAGON) begin
				if (kind_q == KIND_BUS_RD) begin
					if (hit_st_q == ST_M) begin
						new_st      = ST_SM;
						res_d.flush = 1'b1;
					end else if (hit_st_q == ST_SM) begin
						res_d.flush = 1'b1;
					end else if (hit_st_q == ST_E) begin
						new_st = ST_S;
					end
				end else if (kind_q == KIND_BUS_UPDATE) begin
					if (hit_st_q == ST_SM) new_st = ST_S;
				end
			end else if (kind_q == KIND_BUS_RD) begin
				if (hit_st_q == ST_M) begin
					new_st      = ST_S;
					res_d.flush = 1'b1;
				end else if (hit_st_q == ST_E && mode == MODE_MESI) begin
					new_st = ST_S;
				end
			end else if (kind_q == KIND_BUS_RDX) begin
				if (hit_st_q == ST_M) begin
					new_st      = ST_I;
					res_d.flush = 1'b1;
				end else if (hit_st_q == ST_S) begin
					new_st = ST_I;
				end else if (hit_st_q == ST_E && mode == MODE_MESI) begin
					new_st = ST_I;
				end
			end else if (kind_q == KIND_BUS_UPGR && mode == MODE_MESI) begin
				if (hit_st_q == ST_S) new_st = ST_I;
			end
		end
		res_d.line_state = new_st;
	end

	assign st_wd  = (state_q == S_CLR) ? ST_I : new_st;
	assign age_wd = (state_q == S_CLR) ? '0 : count_q;

	// line memories: one read and one write port
	always_ff @(posedge clk) begin
		tag_rd_q <= tag_mem[rd_idx];
		st_rd_q  <= st_mem[rd_idx];
		age_rd_q <= age_mem[rd_idx];
		if (state_q == S_CLR || (fin_go && wr_st)) st_mem[wr_idx] <= st_wd;
		if (state_q == S_CLR || (fin_go && wr_age)) age_mem[wr_idx] <= age_wd;
		if (fin_go && wr_tag) tag_mem[wr_idx] <= tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q <= PROTO_MESI;
		end else if (cfg_we) begin
			protocol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			count_q        <= '0;
			way_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LINE_W'(LINES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_xfer) begin
						count_q <= count_q + 1'b1;
						way_q   <= '0;
						if (item.kind > KIND_BUS_UPDATE) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (last_way) begin
						state_q <= S_FIN;
					end else begin
						way_q   <= way_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_FIN: begin
					if (fin_go) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item latch and way scan
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			kind_q      <= item.kind;
			others_q    <= item.others_have_copy;
			set_q       <= SET_IW'((item.address >> OFF_W) & ADDR_BITS'(SET_MASK));
			tag_q       <= item.address[ADDR_BITS-1 -: TAG_W];
			found_q     <= 1'b0;
			inv_found_q <= 1'b0;
		end
		if (state_q == S_CMP) begin
			if (!found_q && st_rd_q != ST_I && tag_rd_q == tag_q) begin
				found_q   <= 1'b1;
				hit_way_q <= way_q;
				hit_st_q  <= st_rd_q;
			end
			if (!inv_found_q && st_rd_q == ST_I) begin
				inv_found_q <= 1'b1;
				inv_way_q   <= way_q;
			end
			// ties go to the higher way
			if (way_q == '0 || age_rd_q <= min_age_q) begin
				min_age_q <= age_rd_q;
				min_way_q <= way_q;
				min_st_q  <= st_rd_q;
			end
		end
		if (fin_go) result_q <= res_d;
	end

	`SCCC_ASSERT_NOW(a_flush_on_hit, result_valid_q && result_q.flush, result_q.hit,
		"flush without a hit")
	`SCCC_ASSERT_NOW(a_wb_on_fill, result_valid_q && result_q.victim_writeback,
		!result_q.hit, "victim writeback on a hit")
	`SCCC_ASSERT_NOW(a_one_excl_req, result_valid_q, $onehot0(req_vec),
		"more than one ownership request in one result")
	`SCCC_ASSERT_NEXT(a_result_from_fin, state_q != S_FIN && !result_valid_q,
		!result_valid_q, "result appeared outside the write-back cycle")

endmodule
